@@ hw/rtl/dual_channel_waveform_generator_assert.svh @@
// Assertion macros for the dual channel waveform generator.
`ifndef DUAL_CHANNEL_WAVEFORM_GENERATOR_ASSERT_SVH
`define DUAL_CHANNEL_WAVEFORM_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DCWG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DCWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dcwg_pkg.sv @@
// Types and constants shared by the waveform generator modules.
package dcwg_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int MODE_W      = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = MODE_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_A = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE_B = 1'b1;

  localparam logic [SAMPLE_W-1:0] SQUARE_LOW  = 8'h00;
  localparam logic [SAMPLE_W-1:0] SQUARE_HIGH = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAWTOOTH = 3'd3,
    WAVE_POT      = 3'd4
  } wave_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pot_a;
    logic [SAMPLE_W-1:0] pot_b;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } out_item_t;

  // round(127.5 + 127.5*sin(2*pi*k/256))
  localparam logic [SAMPLE_W-1:0] SINE_ROM [256] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
    8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
    8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
    8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
    8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
    8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
    8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
    8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
    8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
    8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
    8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
    8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

@@ hw/rtl/dcwg_channel.sv @@
// One DDS channel: phase accumulator and waveform select.
module dcwg_channel
  import dcwg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [SAMPLE_W-1:0] pot,
  input  wave_mode_t          mode,
  output logic [SAMPLE_W-1:0] sample
);

  logic [SAMPLE_W-1:0] phase;
  logic [SAMPLE_W-1:0] phase_next;
  logic [SAMPLE_W-3:0] step;

  // pot/4, with a zero step forced to one
  always_comb begin
    step = pot[SAMPLE_W-1:2];
    if (step == '0) begin
      step = {{(SAMPLE_W-3){1'b0}}, 1'b1};
    end
    phase_next = phase + {2'b00, step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    unique case (mode)
      WAVE_SINE:     sample = SINE_ROM[phase];
      WAVE_SQUARE:   sample = phase[SAMPLE_W-1] ? SQUARE_HIGH : SQUARE_LOW;
      WAVE_TRIANGLE: sample = phase[SAMPLE_W-1] ? (SAMPLE_W'(0) - phase) : phase;
      WAVE_SAWTOOTH: sample = phase;
      WAVE_POT:      sample = {2'b00, pot[SAMPLE_W-1:2]};
      default:       sample = '0;
    endcase
  end

endmodule

@@ hw/rtl/dual_channel_waveform_generator.sv @@
// Channel  | Signals                          | Direction | Payload
// item     | item_valid, item_ready, item     | in        | pot_a, pot_b
// result   | result_valid, result_ready, result | out     | sample_a, sample_b
// config   | cfg_we, cfg_index, cfg_data      | in        | mode_a, mode_b
// One item per cycle unless the result stalls; items pass the input register, then the result register.
// The phase of each channel advances when an item moves from the input register
// to the result register. Reset clears valid flags and phases, and sets square on A
// and sine on B. A stalled result holds in its register; the input register keeps
// taking items until it is full too, then item_ready drops.
module dual_channel_waveform_generator
  import dcwg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_item_t              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "dual_channel_waveform_generator_assert.svh"

  wave_mode_t          mode_a;
  wave_mode_t          mode_b;
  logic                hold_valid;
  in_item_t            hold_item;
  logic                out_load;
  logic                hold_fire;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_a <= WAVE_SQUARE;
      mode_b <= WAVE_SINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_A: mode_a <= wave_mode_t'(cfg_data);
        CFG_MODE_B: mode_b <= wave_mode_t'(cfg_data);
        default:    ;
      endcase
    end
  end

  assign out_load   = !result_valid || result_ready;
  assign hold_fire  = hold_valid && out_load;
  assign item_ready = !hold_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_item <= item;
    end
  end

  dcwg_channel u_chan_a (
    .clk     (clk),
    .rst     (rst),
    .advance (hold_fire),
    .pot     (hold_item.pot_a),
    .mode    (mode_a),
    .sample  (sample_a)
  );

  dcwg_channel u_chan_b (
    .clk     (clk),
    .rst     (rst),
    .advance (hold_fire),
    .pot     (hold_item.pot_b),
    .mode    (mode_b),
    .sample  (sample_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire) begin
      result.sample_a <= sample_a;
      result.sample_b <= sample_b;
    end
  end

  `DCWG_ASSERT_NOW(a_stall_full, !item_ready, hold_valid && result_valid, "ready low with room")
  `DCWG_ASSERT_NOW(a_no_bubble, hold_valid && !result_valid, hold_fire, "held item not moved")
  `DCWG_ASSERT_NEXT(a_fire_result, hold_fire, result_valid, "transfer into result register lost")

endmodule
